// ===== rtl/block_transfer_command_splitter_defines.svh =====
// assertion macros for the block transfer command splitter
// no dependencies; included by the top level only
`ifndef BLOCK_TRANSFER_COMMAND_SPLITTER_DEFINES_SVH
`define BLOCK_TRANSFER_COMMAND_SPLITTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BTCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define BTCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/btcs_pkg.sv =====
// shared types and constants of the block transfer command splitter
// no dependencies; used by btcs_alu and the top level
package btcs_pkg;

  localparam int MAX_CHUNKS  = 64;
  localparam int CHUNK_LIMIT = 65535;
  localparam int MAX_UNITS   = 16;

  localparam logic [31:0] BLOCK_CAP = 32'(MAX_CHUNKS * CHUNK_LIMIT);

  // result status codes
  localparam logic [2:0] ST_ISSUE     = 3'd0;
  localparam logic [2:0] ST_NOTHING   = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NO_MEDIA  = 3'd3;
  localparam logic [2:0] ST_PROTECTED = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd5;

  // command opcodes and lengths
  localparam logic [7:0] OP_READ10  = 8'h28;
  localparam logic [7:0] OP_WRITE10 = 8'h2a;
  localparam logic [7:0] OP_READ16  = 8'h88;
  localparam logic [7:0] OP_WRITE16 = 8'h8a;
  localparam logic [4:0] CDB_LEN10  = 5'd10;
  localparam logic [4:0] CDB_LEN16  = 5'd16;

  // register indexes
  localparam logic [2:0] REG_UNIT_COUNT = 3'd0;
  localparam logic [2:0] REG_MEDIA_PRES = 3'd1;
  localparam logic [2:0] REG_MEDIA_RO   = 3'd2;
  localparam logic [2:0] REG_LAST_LBA   = 3'd3;
  localparam logic [2:0] REG_BLK_BYTES  = 3'd4;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RANGE1 = 3'd2;
  localparam logic [2:0] S_RANGE2 = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  typedef struct packed {
    logic sub;
  } alu_ctl_t;

endpackage

// ===== rtl/btcs_alu.sv =====
// shared 64-bit add/subtract unit of the command splitter sequencer
// depends on btcs_pkg
module btcs_alu (
  input  btcs_pkg::alu_ctl_t ctl,
  input  logic [63:0]        a,
  input  logic [63:0]        b,
  output logic [63:0]        sum,
  output logic               borrow
);

  logic [64:0] full;

  assign full   = {1'b0, a} + {1'b0, (ctl.sub ? ~b : b)} + {64'b0, ctl.sub};
  assign sum    = full[63:0];
  assign borrow = ctl.sub & ~full[64];

endmodule

// ===== rtl/block_transfer_command_splitter.sv =====
// block transfer command splitter: one request in, up to 64 command beats out
// sequence: check, range1, range2, then mul and emit per chunk; a failed check or range step
// reports a status-only beat, and emit and report hold while out_stall is high with a beat held
// in_stall is high whenever the sequencer is not idle, so for the whole request plus any
// out_stall hold, with the shared 64-bit adder and the chunk multiplier used once per chunk
// reset (synchronous, rst_n low): sequencer idle, out_valid low, register defaults loaded
`include "block_transfer_command_splitter_defines.svh"

module block_transfer_command_splitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [3:0]  in_unit,
  input  logic [63:0] in_start_block,
  input  logic [31:0] in_block_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_unit_out,
  output logic [7:0]  out_opcode,
  output logic [4:0]  out_command_length,
  output logic [63:0] out_chunk_block,
  output logic [15:0] out_chunk_blocks,
  output logic [31:0] out_chunk_bytes,
  output logic        out_last
);

  // configuration registers
  logic [4:0]  unit_count_r;
  logic        media_present_r;
  logic        media_readonly_r;
  logic [63:0] last_lba_r;
  logic [16:0] block_bytes_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r     <= '0;
      media_present_r  <= 1'b0;
      media_readonly_r <= 1'b0;
      last_lba_r       <= '0;
      block_bytes_r    <= 17'd512;
    end else if (cfg_wr) begin
      case (cfg_idx)
        btcs_pkg::REG_UNIT_COUNT: unit_count_r     <= pwdata[4:0];
        btcs_pkg::REG_MEDIA_PRES: media_present_r  <= pwdata[0];
        btcs_pkg::REG_MEDIA_RO:   media_readonly_r <= pwdata[0];
        btcs_pkg::REG_LAST_LBA:   last_lba_r       <= pwdata;
        btcs_pkg::REG_BLK_BYTES:  block_bytes_r    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      btcs_pkg::REG_UNIT_COUNT: prdata = {59'b0, unit_count_r};
      btcs_pkg::REG_MEDIA_PRES: prdata = {63'b0, media_present_r};
      btcs_pkg::REG_MEDIA_RO:   prdata = {63'b0, media_readonly_r};
      btcs_pkg::REG_LAST_LBA:   prdata = last_lba_r;
      btcs_pkg::REG_BLK_BYTES:  prdata = {47'b0, block_bytes_r};
      default:                  prdata = '0;
    endcase
  end

  // sequencer and request state
  logic [2:0]  state_r, state_nxt;
  logic        op_r, op_nxt;
  logic [3:0]  unit_r, unit_nxt;
  logic [63:0] lba_r, lba_nxt;
  logic [31:0] blocks_r, blocks_nxt;
  logic [31:0] blocks_m1_r, blocks_m1_nxt;
  logic [63:0] diff_r, diff_nxt;
  logic [32:0] prod_r, prod_nxt;
  logic [2:0]  pend_st_r, pend_st_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [7:0]  o_opcode_r, o_opcode_nxt;
  logic [4:0]  o_len_r, o_len_nxt;
  logic [63:0] o_block_r, o_block_nxt;
  logic [15:0] o_count_r, o_count_nxt;
  logic [31:0] o_bytes_r, o_bytes_nxt;
  logic        o_last_r, o_last_nxt;
  logic [3:0]  o_unit_r, o_unit_nxt;

  logic                in_acc;
  logic                out_free;
  logic [4:0]          units;
  logic [15:0]         count;
  logic                is_short;
  btcs_pkg::alu_ctl_t  alu_ctl;
  logic [63:0]         alu_a, alu_b, alu_sum;
  logic                alu_borrow;

  assign in_stall = (state_r != btcs_pkg::S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~ov_r | ~out_stall;
  assign units    = (unit_count_r > 5'(btcs_pkg::MAX_UNITS)) ? 5'(btcs_pkg::MAX_UNITS)
                                                            : unit_count_r;
  assign count    = (blocks_r > 32'(btcs_pkg::CHUNK_LIMIT)) ? 16'(btcs_pkg::CHUNK_LIMIT)
                                                           : blocks_r[15:0];
  assign is_short = (lba_r[63:32] == 32'b0);

  always_comb begin
    alu_ctl.sub = 1'b1;
    alu_a       = last_lba_r;
    alu_b       = lba_r;
    case (state_r)
      btcs_pkg::S_RANGE2: begin
        alu_a = diff_r;
        alu_b = {32'b0, blocks_m1_r};
      end
      btcs_pkg::S_EMIT: begin
        alu_ctl.sub = 1'b0;
        alu_a       = lba_r;
        alu_b       = {48'b0, count};
      end
      default: ;
    endcase
  end

  btcs_alu u_alu (
    .ctl    (alu_ctl),
    .a      (alu_a),
    .b      (alu_b),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    unit_nxt      = unit_r;
    lba_nxt       = lba_r;
    blocks_nxt    = blocks_r;
    blocks_m1_nxt = blocks_m1_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    pend_st_nxt   = pend_st_r;
    ov_nxt        = ov_r & out_stall;
    o_status_nxt  = o_status_r;
    o_opcode_nxt  = o_opcode_r;
    o_len_nxt     = o_len_r;
    o_block_nxt   = o_block_r;
    o_count_nxt   = o_count_r;
    o_bytes_nxt   = o_bytes_r;
    o_last_nxt    = o_last_r;
    o_unit_nxt    = o_unit_r;
    case (state_r)
      btcs_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt     = in_op;
          unit_nxt   = in_unit;
          lba_nxt    = in_start_block;
          blocks_nxt = in_block_total;
          state_nxt  = btcs_pkg::S_CHECK;
        end
      end
      btcs_pkg::S_CHECK: begin
        blocks_m1_nxt = blocks_r - 32'd1;
        state_nxt     = btcs_pkg::S_REPORT;
        if ({1'b0, unit_r} >= units) begin
          pend_st_nxt = btcs_pkg::ST_INVALID;
        end else if (!media_present_r) begin
          pend_st_nxt = btcs_pkg::ST_NO_MEDIA;
        end else if (op_r && media_readonly_r) begin
          pend_st_nxt = btcs_pkg::ST_PROTECTED;
        end else if (blocks_r == 32'b0) begin
          pend_st_nxt = btcs_pkg::ST_NOTHING;
        end else begin
          state_nxt = btcs_pkg::S_RANGE1;
        end
      end
      btcs_pkg::S_RANGE1: begin
        diff_nxt = alu_sum;
        if (alu_borrow) begin
          pend_st_nxt = btcs_pkg::ST_INVALID;
          state_nxt   = btcs_pkg::S_REPORT;
        end else begin
          state_nxt = btcs_pkg::S_RANGE2;
        end
      end
      btcs_pkg::S_RANGE2: begin
        if (alu_borrow || blocks_r > btcs_pkg::BLOCK_CAP) begin
          pend_st_nxt = btcs_pkg::ST_INVALID;
          state_nxt   = btcs_pkg::S_REPORT;
        end else begin
          state_nxt = btcs_pkg::S_MUL;
        end
      end
      btcs_pkg::S_MUL: begin
        prod_nxt  = 33'(count) * 33'(block_bytes_r);
        state_nxt = btcs_pkg::S_EMIT;
      end
      btcs_pkg::S_EMIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_unit_nxt = unit_r;
          if (prod_r[32]) begin
            o_status_nxt = btcs_pkg::ST_BAD_SIZE;
            o_opcode_nxt = '0;
            o_len_nxt    = '0;
            o_block_nxt  = '0;
            o_count_nxt  = '0;
            o_bytes_nxt  = '0;
            o_last_nxt   = 1'b1;
            state_nxt    = btcs_pkg::S_IDLE;
          end else begin
            o_status_nxt = btcs_pkg::ST_ISSUE;
            if (is_short) begin
              o_opcode_nxt = op_r ? btcs_pkg::OP_WRITE10 : btcs_pkg::OP_READ10;
              o_len_nxt    = btcs_pkg::CDB_LEN10;
            end else begin
              o_opcode_nxt = op_r ? btcs_pkg::OP_WRITE16 : btcs_pkg::OP_READ16;
              o_len_nxt    = btcs_pkg::CDB_LEN16;
            end
            o_block_nxt = lba_r;
            o_count_nxt = count;
            o_bytes_nxt = prod_r[31:0];
            o_last_nxt  = (blocks_r == {16'b0, count});
            lba_nxt     = alu_sum;
            blocks_nxt  = blocks_r - {16'b0, count};
            state_nxt   = (blocks_r == {16'b0, count}) ? btcs_pkg::S_IDLE
                                                      : btcs_pkg::S_MUL;
          end
        end
      end
      btcs_pkg::S_REPORT: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_unit_nxt   = unit_r;
          o_status_nxt = pend_st_r;
          o_opcode_nxt = '0;
          o_len_nxt    = '0;
          o_block_nxt  = '0;
          o_count_nxt  = '0;
          o_bytes_nxt  = '0;
          o_last_nxt   = 1'b1;
          state_nxt    = btcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = btcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btcs_pkg::S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    unit_r      <= unit_nxt;
    lba_r       <= lba_nxt;
    blocks_r    <= blocks_nxt;
    blocks_m1_r <= blocks_m1_nxt;
    diff_r      <= diff_nxt;
    prod_r      <= prod_nxt;
    pend_st_r   <= pend_st_nxt;
    o_status_r  <= o_status_nxt;
    o_opcode_r  <= o_opcode_nxt;
    o_len_r     <= o_len_nxt;
    o_block_r   <= o_block_nxt;
    o_count_r   <= o_count_nxt;
    o_bytes_r   <= o_bytes_nxt;
    o_last_r    <= o_last_nxt;
    o_unit_r    <= o_unit_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = o_status_r;
  assign out_unit_out       = o_unit_r;
  assign out_opcode         = o_opcode_r;
  assign out_command_length = o_len_r;
  assign out_chunk_block    = o_block_r;
  assign out_chunk_blocks   = o_count_r;
  assign out_chunk_bytes    = o_bytes_r;
  assign out_last           = o_last_r;

  `BTCS_ASSERT_NEXT(a_accept_starts_check, clk, rst_n, in_acc, state_r == btcs_pkg::S_CHECK, "accepted request did not start the check step")
  `BTCS_ASSERT_NOW(a_status_is_last, clk, rst_n, ov_r && (o_status_r != btcs_pkg::ST_ISSUE), o_last_r, "status beat without last")
  `BTCS_ASSERT_NOW(a_short_cdb_fits, clk, rst_n, ov_r && (o_status_r == btcs_pkg::ST_ISSUE) && (o_len_r == btcs_pkg::CDB_LEN10), (o_block_r[63:32] == 32'b0) && (o_count_r != 16'b0), "10-byte command with out-of-range address or empty chunk")

endmodule

// ===== tb/block_transfer_command_splitter_tb.sv =====
// testbench for block_transfer_command_splitter: random and directed requests, with
// every command beat checked against an in-bench prediction of the chunk split
// depends on btcs_pkg and the block_transfer_command_splitter rtl
`timescale 1ns / 100ps

module block_transfer_command_splitter_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic        op;
    logic [3:0]  unit;
    logic [63:0] lba;
    logic [31:0] total;
  } xfer_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  unit;
    logic [7:0]  opcode;
    logic [4:0]  cdb_len;
    logic [63:0] blk;
    logic [15:0] blocks;
    logic [31:0] bytes;
    logic        last;
  } cmd_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = 1'b0;
  logic [3:0]  in_unit = '0;
  logic [63:0] in_start_block = '0;
  logic [31:0] in_block_total = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [3:0]  out_unit_out;
  logic [7:0]  out_opcode;
  logic [4:0]  out_command_length;
  logic [63:0] out_chunk_block;
  logic [15:0] out_chunk_blocks;
  logic [31:0] out_chunk_bytes;
  logic        out_last;

  // bench copy of the register file
  logic [4:0]  cfg_units = 5'd0;
  logic        cfg_present = 1'b0;
  logic        cfg_readonly = 1'b0;
  logic [63:0] cfg_last_lba = '0;
  logic [16:0] cfg_blk_bytes = 17'd512;

  xfer_req_t pending_reqs[$];
  cmd_beat_t expected_beats[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int reqs_taken = 0;
  int beats_checked = 0;
  int cfg_writes = 0;

  block_transfer_command_splitter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_unit           (in_unit),
    .in_start_block    (in_start_block),
    .in_block_total    (in_block_total),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_unit_out      (out_unit_out),
    .out_opcode        (out_opcode),
    .out_command_length(out_command_length),
    .out_chunk_block   (out_chunk_block),
    .out_chunk_blocks  (out_chunk_blocks),
    .out_chunk_bytes   (out_chunk_bytes),
    .out_last          (out_last)
  );

  initial forever #2 clk = ~clk;

  function automatic void push_status(input logic [2:0] code, input logic [3:0] unit);
    cmd_beat_t b;
    b = '0;
    b.status = code;
    b.unit = unit;
    b.last = 1'b1;
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_commands(input xfer_req_t r);
    logic [63:0] lba;
    logic [31:0] left;
    logic [15:0] count;
    logic [32:0] bytes;
    logic [5:0]  units;
    logic [31:0] chunks;
    cmd_beat_t   b;
    lba = r.lba;
    left = r.total;
    units = (cfg_units > btcs_pkg::MAX_UNITS) ? 6'(btcs_pkg::MAX_UNITS) : 6'(cfg_units);
    if (6'(r.unit) >= units) begin
      push_status(btcs_pkg::ST_INVALID, r.unit);
      return;
    end
    if (!cfg_present) begin
      push_status(btcs_pkg::ST_NO_MEDIA, r.unit);
      return;
    end
    if (r.op && cfg_readonly) begin
      push_status(btcs_pkg::ST_PROTECTED, r.unit);
      return;
    end
    if (left == 32'd0) begin
      push_status(btcs_pkg::ST_NOTHING, r.unit);
      return;
    end
    if (lba > cfg_last_lba || (64'(left) - 64'd1) > (cfg_last_lba - lba)) begin
      push_status(btcs_pkg::ST_INVALID, r.unit);
      return;
    end
    chunks = left / 32'(btcs_pkg::CHUNK_LIMIT)
           + (((left % 32'(btcs_pkg::CHUNK_LIMIT)) != 32'd0) ? 32'd1 : 32'd0);
    if (chunks > 32'(btcs_pkg::MAX_CHUNKS)) begin
      push_status(btcs_pkg::ST_INVALID, r.unit);
      return;
    end
    while (left != 32'd0) begin
      count = (left > 32'(btcs_pkg::CHUNK_LIMIT)) ? 16'(btcs_pkg::CHUNK_LIMIT) : left[15:0];
      bytes = 33'(count) * 33'(cfg_blk_bytes);
      if (bytes[32]) begin
        push_status(btcs_pkg::ST_BAD_SIZE, r.unit);
        return;
      end
      b.status = btcs_pkg::ST_ISSUE;
      b.unit = r.unit;
      if (lba <= 64'hffff_ffff) begin
        b.opcode = r.op ? btcs_pkg::OP_WRITE10 : btcs_pkg::OP_READ10;
        b.cdb_len = btcs_pkg::CDB_LEN10;
      end else begin
        b.opcode = r.op ? btcs_pkg::OP_WRITE16 : btcs_pkg::OP_READ16;
        b.cdb_len = btcs_pkg::CDB_LEN16;
      end
      b.blk = lba;
      b.blocks = count;
      b.bytes = bytes[31:0];
      b.last = (left == 32'(count));
      expected_beats.push_back(b);
      lba = lba + 64'(count);
      left = left - 32'(count);
    end
  endfunction

  function automatic xfer_req_t random_request();
    xfer_req_t   r;
    logic [63:0] span;
    logic [63:0] r64;
    logic [4:0]  eff;
    eff = (cfg_units > btcs_pkg::MAX_UNITS) ? 5'(btcs_pkg::MAX_UNITS) : cfg_units;
    r.op = 1'($urandom_range(0, 1));
    if (eff != 5'd0 && $urandom_range(0, 9) != 0)
      r.unit = 4'($urandom_range(0, int'(eff) - 1));
    else
      r.unit = 4'($urandom_range(0, 15));
    r64 = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 65) begin
      case ($urandom_range(0, 9))
        0, 1, 2: r.total = $urandom_range(1, 16);
        3, 4, 5, 6: r.total = $urandom_range(1, 200000);
        7: r.total = $urandom_range(65530, 65540);
        8: r.total = $urandom_range(4000000, 4194241);
        default: r.total = $urandom_range(131060, 131080);
      endcase
      if ((64'(r.total) - 64'd1) > cfg_last_lba) r.total = cfg_last_lba[31:0] + 32'd1;
      span = cfg_last_lba - (64'(r.total) - 64'd1);
      case ($urandom_range(0, 3))
        0: r.lba = span;
        1: r.lba = (span >= 64'hffff_ffff) ? 64'hffff_ffff - 64'($urandom_range(0, 70000))
                                           : span / 2;
        default: r.lba = (span == '1) ? r64 : r64 % (span + 64'd1);
      endcase
    end else begin
      r.lba = r64;
      if ($urandom_range(0, 1) == 0) r.lba = cfg_last_lba - 64'($urandom_range(0, 3));
      r.total = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 15) == 0) r.total = '0;
    end
    return r;
  endfunction

  task automatic push_req(input logic op, input logic [3:0] unit, input logic [63:0] lba,
                          input logic [31:0] total);
    pending_reqs.push_back('{op, unit, lba, total});
  endtask

  task automatic push_random(input int n);
    repeat (n) pending_reqs.push_back(random_request());
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_writes++;
    case (idx)
      btcs_pkg::REG_UNIT_COUNT: cfg_units = val[4:0];
      btcs_pkg::REG_MEDIA_PRES: cfg_present = val[0];
      btcs_pkg::REG_MEDIA_RO:   cfg_readonly = val[0];
      btcs_pkg::REG_LAST_LBA:   cfg_last_lba = val;
      btcs_pkg::REG_BLK_BYTES:  cfg_blk_bytes = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_media(input logic [4:0] units, input logic present, input logic ro,
                           input logic [63:0] last, input logic [16:0] blk_bytes);
    cfg_write(btcs_pkg::REG_UNIT_COUNT, 64'(units));
    cfg_write(btcs_pkg::REG_MEDIA_PRES, 64'(present));
    cfg_write(btcs_pkg::REG_MEDIA_RO, 64'(ro));
    cfg_write(btcs_pkg::REG_LAST_LBA, last);
    cfg_write(btcs_pkg::REG_BLK_BYTES, 64'(blk_bytes));
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_in
    xfer_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_commands('{in_op, in_unit, in_start_block, in_block_total});
        reqs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= r.op;
          in_unit <= r.unit;
          in_start_block <= r.lba;
          in_block_total <= r.total;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_out
    cmd_beat_t got;
    cmd_beat_t want;
    logic      stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_status, out_unit_out, out_opcode, out_command_length, out_chunk_block,
               out_chunk_blocks, out_chunk_bytes, out_last};
        beats_checked++;
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected beat: status %0d unit %0d opcode %h len %0d blk %h cnt %0d bytes %0d last %0d",
                     got.status, got.unit, got.opcode, got.cdb_len, got.blk, got.blocks,
                     got.bytes, got.last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("beat mismatch: expected status %0d unit %0d opcode %h len %0d blk %h cnt %0d bytes %0d last %0d",
                       want.status, want.unit, want.opcode, want.cdb_len, want.blk,
                       want.blocks, want.bytes, want.last);
              $display("               actual   status %0d unit %0d opcode %h len %0d blk %h cnt %0d bytes %0d last %0d",
                       got.status, got.unit, got.opcode, got.cdb_len, got.blk,
                       got.blocks, got.bytes, got.last);
            end
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(0, 99) < recv_idle_pct);
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 52;

    // reset defaults: no usable units
    push_req(1'b0, 4'd0, 64'd0, 32'd1);
    push_random(10);
    wait_drain();

    set_media(5'd4, 1'b1, 1'b0, '1, 17'd512);
    push_req(1'b0, 4'd3, 64'd0, 32'd1);
    push_req(1'b1, 4'd4, 64'd0, 32'd1);
    push_req(1'b0, 4'd0, 64'd0, 32'd0);
    push_req(1'b1, 4'd1, 64'hffff_ffff, 32'd2);
    push_req(1'b0, 4'd2, 64'h1_0000_0000, 32'd1);
    push_req(1'b1, 4'd0, 64'd0, 32'd65535);
    push_req(1'b0, 4'd1, 64'd0, 32'd65536);
    push_req(1'b0, 4'd2, 64'hffff_0000, 32'd4194240);
    push_req(1'b1, 4'd3, 64'd0, 32'd4194241);
    push_req(1'b0, 4'd0, '1, 32'd1);
    push_req(1'b0, 4'd0, '1, 32'd2);
    push_req(1'b1, 4'd1, 64'hffff_ffff_ffff_fffe, 32'hffff_ffff);
    push_req(1'b0, 4'd15, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
    push_random(40);
    wait_drain();

    // unit count above the unit limit, write protected, zero block size
    set_media(5'd31, 1'b1, 1'b1, {8'h00, 24'($urandom), $urandom}, 17'd0);
    push_req(1'b1, 4'd15, 64'd0, 32'd1);
    push_req(1'b0, 4'd15, 64'd0, 32'd3);
    push_random(35);
    wait_drain();

    send_idle_pct = 52;
    recv_idle_pct = 22;

    set_media(5'd16, 1'b0, 1'b0, '1, 17'd4096);
    push_req(1'b0, 4'd5, 64'd0, 32'd1);
    push_req(1'b1, 4'd0, 64'd7, 32'd9);
    push_random(15);
    wait_drain();

    // oversized chunks; long receiver hold-off while the sender keeps offering
    set_media(5'd9, 1'b1, 1'b0, {1'b1, 31'($urandom), $urandom}, 17'd65537);
    push_req(1'b0, 4'd0, 64'd0, 32'd65535);
    push_req(1'b1, 4'd1, 64'd0, 32'd65534);
    push_random(25);
    hold_requests++;
    wait_drain();
    push_random(25);
    wait_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;

    set_media(5'd1, 1'b1, 1'b0, 64'd0, 17'd65536);
    push_req(1'b0, 4'd0, 64'd0, 32'd1);
    push_req(1'b0, 4'd0, 64'd0, 32'd2);
    push_req(1'b1, 4'd0, 64'd1, 32'd1);
    push_random(30);
    wait_drain();

    set_media(5'd16, 1'b1, 1'b1, '1, 17'h1ffff);
    push_random(50);
    wait_drain();

    set_media(5'd2, 1'b1, 1'b0, 64'h1_0000_ffff, 17'd1);
    push_random(40);
    wait_drain();

    $display("covered %0d requests and %0d command beats across %0d register writes",
             reqs_taken, beats_checked, cfg_writes);
    $display("unit, media, protection, range, chunk count and buffer size limits exercised");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
